[hw/rtl/fbab_pkg.sv]
// Shared types and constants for the framebuffer alpha blend pixel unit.
package fbab_pkg;

   localparam int PIXEL_COORD_W = 11;
   localparam int COLOR_W       = 8;
   localparam int ALPHA_W       = 9;
   localparam int WORD_W        = 32;
   localparam int ADDR_W        = 24;
   localparam int LANES_W       = 4;
   localparam int BPP_W         = 6;
   localparam int STRIDE_W      = 14;
   localparam int CSR_ADDR_W    = 3;
   localparam int CSR_DATA_W    = 32;

   localparam logic [ALPHA_W-1:0] ALPHA_ONE = 9'd256;

   localparam logic [BPP_W-1:0] DEPTH_16 = 6'd16;
   localparam logic [BPP_W-1:0] DEPTH_24 = 6'd24;
   localparam logic [BPP_W-1:0] DEPTH_32 = 6'd32;
   localparam logic [BPP_W-1:0] BPP_RESET    = DEPTH_32;
   localparam logic [STRIDE_W-1:0] STRIDE_RESET = '0;

   localparam logic [LANES_W-1:0] LANES_NONE = 4'b0000;
   localparam logic [LANES_W-1:0] LANES_16   = 4'b0011;
   localparam logic [LANES_W-1:0] LANES_RGB  = 4'b0111;

   // Register index is bit 2 of the byte address.
   localparam logic CSR_IDX_BPP    = 1'b0;
   localparam logic CSR_IDX_STRIDE = 1'b1;

   typedef enum logic [1:0] {
      FMT_16,
      FMT_24,
      FMT_32,
      FMT_BAD
   } fmt_type;

   typedef struct packed {
      logic [PIXEL_COORD_W-1:0] pixel_x;
      logic [PIXEL_COORD_W-1:0] pixel_y;
      logic [COLOR_W-1:0]       src_red;
      logic [COLOR_W-1:0]       src_green;
      logic [COLOR_W-1:0]       src_blue;
      logic [ALPHA_W-1:0]       alpha_frac;
      logic [WORD_W-1:0]        background_pixel;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0]  byte_address;
      logic [WORD_W-1:0]  blended_pixel;
      logic [LANES_W-1:0] lane_mask;
      logic               unsupported_depth;
   } rsp_type;

   typedef struct packed {
      logic [BPP_W-1:0]    color_depth;
      logic [STRIDE_W-1:0] line_stride_bytes;
   } cfg_type;

endpackage

[hw/rtl/framebuffer_alpha_blend_pixel.sv]
// Top level of the framebuffer alpha blend pixel unit with its pipeline registers.
// Usage: a drawing engine presents one pixel per transfer on the req_ channel
// (coordinates, source color, alpha out of 256 and the background word read
// from the framebuffer). Each pixel yields exactly one transfer on the rsp_
// channel carrying the byte address, the word to write, its byte-lane mask
// and a flag for an unsupported color depth (mask zero, word unchanged).
// A pixel taken from req_ is captured in the input register, and its answer
// is registered in the result register. Throughput is one pixel per cycle
// while the receiver does not stall; the datapath between the two registers
// is a single pass of three channel blenders (two small multipliers each)
// and the address multiply-add, with no state carried from pixel to pixel.
// When the receiver stalls, the result register holds its transfer and the
// input register can still take one more pixel; req_stall rises only when
// both registers are full and the result is stalled. Reset clears both valid
// flags and sets the depth to 32 bits per pixel and the line stride to zero.
// The user writes depth (offset 0) and stride (offset 4) through the APB-style
// port only while no pixel is in flight; the block does not enforce this.
module framebuffer_alpha_blend_pixel #(
   parameter int MAX_COORD_BITS = 11
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  fbab_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output fbab_pkg::rsp_type                 rsp_data,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [fbab_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [fbab_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [fbab_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready
);
   import fbab_pkg::*;

   cfg_type cfg;

   logic    s1_vld_ff;
   logic    s1_vld_in;
   req_type s1_data_ff;
   req_type s1_data_in;
   logic    rsp_vld_ff;
   logic    rsp_vld_in;
   rsp_type rsp_data_ff;
   rsp_type rsp_data_in;
   rsp_type calc;
   logic    adv_rsp;
   logic    take_req;

   fbab_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   fbab_pixel #(
      .COORD_BITS (MAX_COORD_BITS)
   ) u_pixel (
      .cfg  (cfg),
      .item (s1_data_ff),
      .res  (calc)
   );

   // The result register advances when it is empty or its transfer completes.
   assign adv_rsp   = !rsp_vld_ff || !rsp_stall;
   assign req_stall = s1_vld_ff && !adv_rsp;
   assign take_req  = req_valid && !req_stall;

   always_comb begin
      s1_vld_in  = s1_vld_ff;
      s1_data_in = s1_data_ff;
      if (take_req) begin
         s1_vld_in  = 1'b1;
         s1_data_in = req_data;
      end else if (adv_rsp) begin
         s1_vld_in = 1'b0;
      end
   end

   always_comb begin
      rsp_vld_in  = rsp_vld_ff;
      rsp_data_in = rsp_data_ff;
      if (adv_rsp) begin
         rsp_vld_in = s1_vld_ff;
         if (s1_vld_ff) begin
            rsp_data_in = calc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff  <= s1_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // Payload registers carry no reset; their valid flags qualify them.
   always_ff @(posedge clock) begin
      s1_data_ff  <= s1_data_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_data_ff;

   // Back-pressure reaches the input only when both registers hold pixels.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_vld_ff && rsp_vld_ff))
      else $error("input stalled while a pipeline register was free");

   // A pixel leaving the input register always lands in the result register.
   assert property (@(posedge clock) disable iff (reset)
      (s1_vld_ff && adv_rsp) |=> rsp_vld_ff)
      else $error("pixel lost between input and result registers");

   // An unsupported depth gives no lanes and a zero address.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && rsp_data_ff.unsupported_depth) |->
         (rsp_data_ff.lane_mask == LANES_NONE && rsp_data_ff.byte_address == '0))
      else $error("unsupported depth with nonzero lane mask or address");

   // A supported depth writes either the 16-bit or the RGB lanes.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && !rsp_data_ff.unsupported_depth) |->
         (rsp_data_ff.lane_mask == LANES_16 || rsp_data_ff.lane_mask == LANES_RGB))
      else $error("supported depth with unexpected lane mask");

endmodule

[hw/rtl/fbab_csr.sv]
// Configuration registers of the alpha blend unit behind an APB-style port.
module fbab_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [fbab_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [fbab_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [fbab_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready,
   output fbab_pkg::cfg_type                 cfg
);
   import fbab_pkg::*;

   logic          wr_en;
   logic          reg_idx;
   cfg_type       cfg_ff;
   cfg_type       cfg_in;

   assign pready  = 1'b1;
   assign reg_idx = paddr[2];
   assign wr_en   = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            CSR_IDX_BPP:    cfg_in.color_depth       = pwdata[BPP_W-1:0];
            CSR_IDX_STRIDE: cfg_in.line_stride_bytes = pwdata[STRIDE_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.color_depth       <= BPP_RESET;
         cfg_ff.line_stride_bytes <= STRIDE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (reg_idx)
         CSR_IDX_BPP:    prdata = CSR_DATA_W'(cfg_ff.color_depth);
         CSR_IDX_STRIDE: prdata = CSR_DATA_W'(cfg_ff.line_stride_bytes);
         default:        prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

[hw/rtl/fbab_chan.sv]
// One color channel blend: (a*src + (256-a)*bg) >> 8.
module fbab_chan (
   input  logic [fbab_pkg::ALPHA_W-1:0] alpha,
   input  logic [fbab_pkg::COLOR_W-1:0] src,
   input  logic [fbab_pkg::COLOR_W-1:0] bg,
   output logic [fbab_pkg::COLOR_W-1:0] blended
);
   import fbab_pkg::*;

   logic [ALPHA_W-1:0] inv_alpha;
   logic [15:0]        fg_prod;
   logic [15:0]        bg_prod;
   logic [15:0]        sum;

   // Alpha is at most 256, so the weighted sum never exceeds 256*255.
   assign inv_alpha = ALPHA_ONE - alpha;
   assign fg_prod   = 16'(alpha) * 16'(src);
   assign bg_prod   = 16'(inv_alpha) * 16'(bg);
   assign sum       = fg_prod + bg_prod;
   assign blended   = sum[15:8];

endmodule

[hw/rtl/fbab_pixel.sv]
// Per-pixel datapath: format decode, byte address and blended word.
module fbab_pixel #(
   parameter int COORD_BITS = 11
) (
   input  fbab_pkg::cfg_type cfg,
   input  fbab_pkg::req_type item,
   output fbab_pkg::rsp_type res
);
   import fbab_pkg::*;

   localparam int CoordW = (COORD_BITS < PIXEL_COORD_W) ? COORD_BITS : PIXEL_COORD_W;

   fmt_type              fmt;
   logic [ALPHA_W-1:0]   alpha_sat;
   logic [CoordW-1:0]    x_c;
   logic [CoordW-1:0]    y_c;
   logic [CoordW+1:0]    x_off;
   logic [CoordW+STRIDE_W-1:0] y_off;
   logic [ADDR_W-1:0]    addr_sum;
   logic [WORD_W-1:0]    bgw;
   logic [COLOR_W-1:0]   bg_r;
   logic [COLOR_W-1:0]   bg_g;
   logic [COLOR_W-1:0]   bg_b;
   logic [COLOR_W-1:0]   new_r;
   logic [COLOR_W-1:0]   new_g;
   logic [COLOR_W-1:0]   new_b;

   always_comb begin
      unique case (cfg.color_depth)
         DEPTH_16: fmt = FMT_16;
         DEPTH_24: fmt = FMT_24;
         DEPTH_32: fmt = FMT_32;
         default:  fmt = FMT_BAD;
      endcase
   end

   assign alpha_sat = (item.alpha_frac > ALPHA_ONE) ? ALPHA_ONE : item.alpha_frac;
   assign bgw       = item.background_pixel;

   // Address: x times bytes per pixel, plus y times the line stride.
   assign x_c = item.pixel_x[CoordW-1:0];
   assign y_c = item.pixel_y[CoordW-1:0];

   always_comb begin
      unique case (fmt)
         FMT_16:  x_off = {1'b0, x_c, 1'b0};
         FMT_24:  x_off = {1'b0, x_c, 1'b0} + {2'b00, x_c};
         FMT_32:  x_off = {x_c, 2'b00};
         default: x_off = '0;
      endcase
   end

   assign y_off    = (CoordW+STRIDE_W)'(y_c) * (CoordW+STRIDE_W)'(cfg.line_stride_bytes);
   assign addr_sum = ADDR_W'(x_off) + ADDR_W'(y_off);

   // Background channel per format; RGB565 fields are widened by shifting.
   always_comb begin
      unique case (fmt)
         FMT_16: begin
            bg_r = {bgw[15:11], 3'b000};
            bg_g = {bgw[10:5], 2'b00};
            bg_b = {bgw[4:0], 3'b000};
         end
         FMT_24: begin
            bg_r = bgw[7:0];
            bg_g = bgw[15:8];
            bg_b = bgw[23:16];
         end
         default: begin
            bg_r = bgw[23:16];
            bg_g = bgw[15:8];
            bg_b = bgw[7:0];
         end
      endcase
   end

   fbab_chan u_chan_r (
      .alpha   (alpha_sat),
      .src     (item.src_red),
      .bg      (bg_r),
      .blended (new_r)
   );

   fbab_chan u_chan_g (
      .alpha   (alpha_sat),
      .src     (item.src_green),
      .bg      (bg_g),
      .blended (new_g)
   );

   fbab_chan u_chan_b (
      .alpha   (alpha_sat),
      .src     (item.src_blue),
      .bg      (bg_b),
      .blended (new_b)
   );

   always_comb begin
      res.byte_address      = addr_sum;
      res.unsupported_depth = 1'b0;
      unique case (fmt)
         FMT_16: begin
            res.blended_pixel = {bgw[31:16], new_r[7:3], new_g[7:2], new_b[7:3]};
            res.lane_mask     = LANES_16;
         end
         FMT_24: begin
            res.blended_pixel = {bgw[31:24], new_b, new_g, new_r};
            res.lane_mask     = LANES_RGB;
         end
         FMT_32: begin
            res.blended_pixel = {bgw[31:24], new_r, new_g, new_b};
            res.lane_mask     = LANES_RGB;
         end
         default: begin
            res.byte_address      = '0;
            res.blended_pixel     = bgw;
            res.lane_mask         = LANES_NONE;
            res.unsupported_depth = 1'b1;
         end
      endcase
   end

endmodule
